// ===== src/dzf_pkg.sv =====
// Shared widths, types and helpers for the dead zone follow smoother.
`default_nettype none

package dzf_pkg;

  // Coordinate and register widths.
  localparam int COORD_BITS = 25;
  localparam int DZ_W       = 23;
  localparam int DIV_W      = 11;
  localparam int WORLD_W    = 16;
  localparam int START_W    = 25;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = ADDR_W - 2;

  // Pixels to centi-pixels.
  localparam int HUND_W = 7;
  localparam logic [HUND_W-1:0] PIX_SCALE = 7'd100;

  // Anchor follow arithmetic: coordinate plus or minus the dead zone.
  localparam int FOLLOW_W = ((COORD_BITS > DZ_W) ? COORD_BITS : DZ_W) + 2;

  // Smoothing: cam * divisor + (anchor - cam), then (2|n| + div) / (2 div).
  localparam int MULB_W    = DIV_W + 1;
  localparam int PROD_W    = COORD_BITS + MULB_W;
  localparam int N_W       = PROD_W + 1;
  localparam int NUM_W     = N_W + 1;
  localparam int DIV_STEPS = (NUM_W + 1) / 2;
  localparam int NUMP_W    = 2 * DIV_STEPS;
  localparam int DEN_W     = DIV_W + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int V_W       = NUMP_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEAD_ZONE = 3'd0,
    REG_DIVISOR   = 3'd1,
    REG_WORLD_W   = 3'd2,
    REG_WORLD_H   = 3'd3,
    REG_START_X   = 3'd4,
    REG_START_Y   = 3'd5
  } reg_idx_t;

  // Control from the top level to one axis lane.
  typedef struct packed {
    logic   start;
    logic   load;
    coord_t load_val;
  } lane_ctl_t;

  // Status from one axis lane.
  typedef struct packed {
    logic   done;
    coord_t view;
  } lane_sts_t;

  // Saturate a wide signed value to the coordinate range.
  function automatic coord_t sat_coord(input logic signed [V_W-1:0] v);
    logic signed [V_W-1:0] hi;
    logic signed [V_W-1:0] lo;
    hi = {{(V_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      sat_coord = hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      sat_coord = lo[COORD_BITS-1:0];
    end else begin
      sat_coord = v[COORD_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/dzf_div.sv =====
// Restoring unsigned divider, two quotient bits per cycle.
`default_nettype none

module dzf_div
  import dzf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUMP_W-1:0] num,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   done,
  output logic [NUMP_W-1:0]      quo
);

  logic              run_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [NUMP_W-1:0] num_r;
  logic [NUMP_W-1:0] quo_r;
  logic [DEN_W-1:0]  rem_r;

  logic [NUMP_W-1:0] num_nxt;
  logic [NUMP_W-1:0] quo_nxt;
  logic [DEN_W-1:0]  rem_nxt;

  always_comb begin
    logic [DEN_W:0] t;
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int k = 0; k < 2; k++) begin
      t       = {rem_nxt, num_nxt[NUMP_W-1]};
      num_nxt = num_nxt << 1;
      if (t >= {1'b0, den}) begin
        t       = t - {1'b0, den};
        quo_nxt = {quo_nxt[NUMP_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[NUMP_W-2:0], 1'b0};
      end
      rem_nxt = t[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== src/dzf_lane.sv =====
// One axis lane: anchor follow, smoothing division, rounding and clamp.
`default_nettype none

module dzf_lane
  import dzf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lane_ctl_t          ctl,
  input  wire coord_t             pos,
  input  wire logic [DZ_W-1:0]    dz,
  input  wire logic [DIV_W-1:0]   div,
  input  wire logic [WORLD_W-1:0] world,
  output lane_sts_t               sts
);

  typedef enum logic [3:0] {
    LP_IDLE  = 4'b0001,
    LP_PREP  = 4'b0010,
    LP_DIV   = 4'b0100,
    LP_CLAMP = 4'b1000
  } lane_phase_t;

  lane_phase_t              phase_r;
  coord_t                   anchor_r;
  coord_t                   cam_r;
  logic                     done_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r;
  logic signed [V_W-1:0]    v_r;

  // Anchor follow.
  logic signed [FOLLOW_W-1:0] p_w;
  logic signed [FOLLOW_W-1:0] a_w;
  logic signed [FOLLOW_W-1:0] d_w;
  logic signed [FOLLOW_W-1:0] anc_w;
  coord_t                     anc_sat;

  always_comb begin
    p_w = FOLLOW_W'(pos);
    a_w = FOLLOW_W'(anchor_r);
    d_w = $signed(FOLLOW_W'(dz));
    if (p_w < a_w - d_w) begin
      anc_w = p_w + d_w;
    end else if (p_w > a_w + d_w) begin
      anc_w = p_w - d_w;
    end else begin
      anc_w = a_w;
    end
    anc_sat = sat_coord(V_W'(anc_w));
  end

  // Scale the current view by the divisor.
  logic signed [MULB_W-1:0] div_s;
  logic signed [PROD_W-1:0] prod_nxt;

  assign div_s    = $signed({1'b0, div});
  assign prod_nxt = cam_r * div_s;

  // Numerator and denominator of the rounded division.
  logic signed [N_W-1:0] n_w;
  logic [N_W-1:0]        mag;
  logic [NUM_W-1:0]      num_w;
  logic [DEN_W-1:0]      den_w;

  assign n_w   = N_W'(prod_r) + (N_W'(anchor_r) - N_W'(cam_r));
  assign mag   = n_w[N_W-1] ? (~n_w + 1'b1) : n_w;
  assign num_w = {mag, 1'b0} + NUM_W'(div);
  assign den_w = {div, 1'b0};

  logic              div_done;
  logic [NUMP_W-1:0] quo;

  dzf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (phase_r == LP_PREP),
    .num   (NUMP_W'(num_w)),
    .den   (den_w),
    .done  (div_done),
    .quo   (quo)
  );

  // Restore the sign, then clamp to the world margins.
  logic signed [V_W-1:0]             qv;
  logic signed [V_W-1:0]             v_nxt;
  logic [WORLD_W+HUND_W-1:0]         w100;
  logic signed [V_W-1:0]             dz_v;
  logic signed [V_W-1:0]             hi_v;
  logic signed [V_W-1:0]             c_v;
  coord_t                            cam_nxt;

  assign qv    = $signed(V_W'(quo));
  assign v_nxt = neg_r ? -qv : qv;

  always_comb begin
    w100 = world * PIX_SCALE;
    dz_v = $signed(V_W'(dz));
    hi_v = $signed(V_W'(w100)) - dz_v;
    if (v_r < dz_v) begin
      c_v = dz_v;
    end else if (v_r > hi_v) begin
      c_v = hi_v;
    end else begin
      c_v = v_r;
    end
    cam_nxt = sat_coord(c_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= LP_IDLE;
      anchor_r <= '0;
      cam_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        LP_IDLE: begin
          if (ctl.load) begin
            anchor_r <= ctl.load_val;
            cam_r    <= ctl.load_val;
          end else if (ctl.start) begin
            anchor_r <= anc_sat;
            phase_r  <= LP_PREP;
          end
        end
        LP_PREP: begin
          phase_r <= LP_DIV;
        end
        LP_DIV: begin
          if (div_done) begin
            phase_r <= LP_CLAMP;
          end
        end
        LP_CLAMP: begin
          cam_r   <= cam_nxt;
          done_r  <= 1'b1;
          phase_r <= LP_IDLE;
        end
        default: begin
          phase_r <= LP_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == LP_IDLE && ctl.start) begin
      prod_r <= prod_nxt;
    end
    if (phase_r == LP_PREP) begin
      neg_r <= n_w[N_W-1];
    end
    if (phase_r == LP_DIV && div_done) begin
      v_r <= v_nxt;
    end
  end

  assign sts.done = done_r;
  assign sts.view = cam_r;

endmodule

`default_nettype wire

// ===== src/dead_zone_follow_smoother.sv =====
// Top level of the dead zone follow smoother: registers, lane control, result register.
//
//   Port group   Direction  Carries
//   in_*         in         followed position request (pos_x, pos_y)
//   out_*        out        smoothed view request (view_x, view_y)
//   p* (APB)     in/out     configuration registers at byte address 4*index
//
// A request passes from acceptance to a valid result through the anchor
// follow, numerator setup, the divider in each axis lane (two quotient bits
// at a time), sign restore, clamp and result load; a new request is taken only
// once the previous result is loaded. The next request is taken the cycle after
// the result is loaded, even if that result is still stalled.
// Reset is synchronous; the view and anchor return to zero.
`default_nettype none

module dead_zone_follow_smoother
  import dzf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire coord_t            in_pos_x,
  input  wire coord_t            in_pos_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output coord_t                 out_view_x,
  output coord_t                 out_view_y,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_PEND = 3'b100
  } top_state_t;

  // Configuration registers.
  logic [DZ_W-1:0]    dead_zone_r;
  logic [DIV_W-1:0]   divisor_r;
  logic [WORLD_W-1:0] world_w_r;
  logic [WORLD_W-1:0] world_h_r;
  logic [START_W-1:0] start_x_r;
  logic [START_W-1:0] start_y_r;

  logic     wr_en;
  reg_idx_t reg_idx;
  coord_t   start_val;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign start_val = sat_coord(V_W'($signed(pwdata[START_W-1:0])));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= '0;
      divisor_r   <= DIV_W'(1);
      world_w_r   <= '0;
      world_h_r   <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEAD_ZONE: dead_zone_r <= pwdata[DZ_W-1:0];
        REG_DIVISOR:   divisor_r   <= pwdata[DIV_W-1:0];
        REG_WORLD_W:   world_w_r   <= pwdata[WORLD_W-1:0];
        REG_WORLD_H:   world_h_r   <= pwdata[WORLD_W-1:0];
        REG_START_X:   start_x_r   <= pwdata[START_W-1:0];
        REG_START_Y:   start_y_r   <= pwdata[START_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEAD_ZONE: prdata = DATA_W'(dead_zone_r);
      REG_DIVISOR:   prdata = DATA_W'(divisor_r);
      REG_WORLD_W:   prdata = DATA_W'(world_w_r);
      REG_WORLD_H:   prdata = DATA_W'(world_h_r);
      REG_START_X:   prdata = DATA_W'(start_x_r);
      REG_START_Y:   prdata = DATA_W'(start_y_r);
      default:       prdata = '0;
    endcase
  end

  // A divisor of zero behaves as one.
  logic [DIV_W-1:0] div_eff;
  assign div_eff = (divisor_r == '0) ? DIV_W'(1) : divisor_r;

  // Request control and the result register.
  top_state_t state_r;
  logic       out_valid_r;
  coord_t     view_x_r;
  coord_t     view_y_r;

  lane_ctl_t ctl_x;
  lane_ctl_t ctl_y;
  lane_sts_t sts_x;
  lane_sts_t sts_y;

  logic start;
  logic lanes_done;
  logic load_out;

  assign start      = (state_r == ST_IDLE) && in_valid;
  assign in_stall   = (state_r != ST_IDLE);
  assign lanes_done = sts_x.done & sts_y.done;
  assign load_out   = ((state_r == ST_BUSY) && lanes_done && (!out_valid_r || !out_stall)) ||
                      ((state_r == ST_PEND) && !out_stall);

  assign ctl_x.start    = start;
  assign ctl_x.load     = wr_en && (reg_idx == REG_START_X);
  assign ctl_x.load_val = start_val;
  assign ctl_y.start    = start;
  assign ctl_y.load     = wr_en && (reg_idx == REG_START_Y);
  assign ctl_y.load_val = start_val;

  dzf_lane u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_x),
    .pos   (in_pos_x),
    .dz    (dead_zone_r),
    .div   (div_eff),
    .world (world_w_r),
    .sts   (sts_x)
  );

  dzf_lane u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_y),
    .pos   (in_pos_y),
    .dz    (dead_zone_r),
    .div   (div_eff),
    .world (world_h_r),
    .sts   (sts_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          // The lanes hold their result, so a stalled output waits in ST_PEND.
          if (lanes_done) begin
            state_r <= load_out ? ST_IDLE : ST_PEND;
          end
        end
        ST_PEND: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      view_x_r <= sts_x.view;
      view_y_r <= sts_y.view;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_view_x = view_x_r;
  assign out_view_y = view_y_r;

endmodule

`default_nettype wire
